/* sv/rlp_pkg.sv */
// rlp_pkg: shared types and constants for the run-length packer
// no dependencies; used by every module of the packer
`default_nettype none

package rlp_pkg;

  localparam int unsigned PixW         = 8;
  localparam int unsigned HdrW         = 8;
  localparam int unsigned ColW         = 16;
  localparam int unsigned MaxRunDef    = 128;
  localparam int unsigned QueueDepthDef = 4;

  localparam logic HdrFlag = 1'b1;  // top bit of every run packet header

  // one classified pixel: one or two packets to send
  typedef struct packed {
    logic            two;
    logic [HdrW-1:0] hdr0;
    logic [PixW-1:0] val0;
    logic [HdrW-1:0] hdr1;
    logic [PixW-1:0] val1;
  } cmd_t;

endpackage

`default_nettype wire

/* sv/rlp_front.sv */
// rlp_front: run tracking and packet classification, one pixel per beat
// depends on rlp_pkg
`default_nettype none

module rlp_front import rlp_pkg::*; #(
  parameter int unsigned MaxRun = MaxRunDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [ColW-1:0] cfg_wdata_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [PixW-1:0] pixel_i,
  input  logic            q_full_i,
  output logic            push_o,
  output cmd_t            cmd_o
);

  localparam int unsigned LenW = $clog2(MaxRun + 1);

  logic [ColW-1:0] row_width_q;
  logic [PixW-1:0] run_val_q, run_val_d;
  logic [LenW-1:0] run_len_q, run_len_d, new_len;
  logic [ColW-1:0] col_q, col_d;
  logic [PixW-1:0] new_val;
  logic [ColW:0]   next_col;
  logic            accept, close_run, row_end;
  logic [HdrW-1:0] close_hdr, end_hdr;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  always_comb begin
    close_run = 1'b0;
    new_val   = pixel_i;
    new_len   = LenW'(1);
    if (run_len_q != '0) begin
      if (pixel_i != run_val_q || run_len_q >= LenW'(MaxRun)) begin
        close_run = 1'b1;
      end else begin
        new_val = run_val_q;
        new_len = run_len_q + LenW'(1);
      end
    end
    next_col  = {1'b0, col_q} + (ColW+1)'(1);
    row_end   = next_col >= {1'b0, row_width_q};
    close_hdr = {HdrFlag, 7'(run_len_q - LenW'(1))};
    end_hdr   = {HdrFlag, 7'(new_len - LenW'(1))};

    run_val_d = new_val;
    run_len_d = row_end ? '0 : new_len;
    col_d     = row_end ? '0 : next_col[ColW-1:0];

    cmd_o.two  = close_run && row_end;
    cmd_o.hdr0 = close_run ? close_hdr : end_hdr;
    cmd_o.val0 = close_run ? run_val_q : new_val;
    cmd_o.hdr1 = end_hdr;
    cmd_o.val1 = new_val;
  end

  assign push_o = accept && (close_run || row_end);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q <= ColW'(1);
      run_val_q   <= '0;
      run_len_q   <= '0;
      col_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        row_width_q <= cfg_wdata_i;
      end
      if (accept) begin
        run_val_q <= run_val_d;
        run_len_q <= run_len_d;
        col_q     <= col_d;
      end
    end
  end

`ifndef NO_ASSERTIONS
  // a nonzero column means the row holds an open run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (col_q != '0) |-> (run_len_q != '0))
    else $error("column advanced without an open run");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_len_q <= LenW'(MaxRun))
    else $error("run length beyond limit");
`endif

endmodule

`default_nettype wire

/* sv/rlp_queue.sv */
// rlp_queue: small register queue of classified pixels between front and back
// depends on rlp_pkg
`default_nettype none

module rlp_queue import rlp_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_data_i,
  input  logic pop_i,
  output cmd_t pop_data_o,
  output logic full_o,
  output logic empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o     = count_q == CntW'(Depth);
  assign empty_o    = count_q == '0;
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

`ifndef NO_ASSERTIONS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("push into full queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count overflow");
`endif

endmodule

`default_nettype wire

/* sv/rlp_back.sv */
// rlp_back: splits classified pixels into packet beats behind an output register
// depends on rlp_pkg
`default_nettype none

module rlp_back import rlp_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_empty_i,
  input  cmd_t            q_data_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [HdrW-1:0] packet_header_o,
  output logic [PixW-1:0] value_o,
  output logic            last_o
);

  logic            out_valid_q, last_q, pend_q;
  logic [HdrW-1:0] hdr_q, pend_hdr_q;
  logic [PixW-1:0] val_q, pend_val_q;
  logic            advance;

  assign advance = !out_valid_q || !out_stall_i;
  assign pop_o   = advance && !pend_q && !q_empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
      last_q      <= 1'b0;
      hdr_q       <= '0;
      val_q       <= '0;
      pend_hdr_q  <= '0;
      pend_val_q  <= '0;
    end else if (advance) begin
      if (pend_q) begin
        out_valid_q <= 1'b1;
        hdr_q       <= pend_hdr_q;
        val_q       <= pend_val_q;
        last_q      <= 1'b1;
        pend_q      <= 1'b0;
      end else if (!q_empty_i) begin
        out_valid_q <= 1'b1;
        hdr_q       <= q_data_i.hdr0;
        val_q       <= q_data_i.val0;
        last_q      <= !q_data_i.two;
        pend_q      <= q_data_i.two;
        pend_hdr_q  <= q_data_i.hdr1;
        pend_val_q  <= q_data_i.val1;
      end else begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign packet_header_o = hdr_q;
  assign value_o         = val_q;
  assign last_o          = last_q;

`ifndef NO_ASSERTIONS
  // a held second packet always sits behind a first one still on the port
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (out_valid_q && !last_q))
    else $error("second packet pending without first");
`endif

endmodule

`default_nettype wire

/* sv/grayscale_run_length_packer.sv */
// a pixel that gives packets is pushed into the queue as it is accepted; the back then pops it
//   and loads its first packet beat into the output register, from which it is offered on the port
// throughput: one pixel per cycle while the output takes one beat per cycle; a pixel that
//   gives two packets holds the output register for two beats; input stalls only on a full queue
// reset: asynchronous, active low; drops any open run, clears the queue, row width = 1
// top level of the run-length packer; depends on rlp_pkg, rlp_front, rlp_queue, rlp_back
`default_nettype none

module grayscale_run_length_packer import rlp_pkg::*; #(
  parameter int unsigned MaxRun     = MaxRunDef,     // 2 .. 128
  parameter int unsigned QueueDepth = QueueDepthDef  // entries between front and back
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  // row width register
  input  logic            cfg_we_i,
  input  logic [ColW-1:0] cfg_wdata_i,
  // pixel beats
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [PixW-1:0] pixel_i,
  // packet beats
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [HdrW-1:0] packet_header_o,
  output logic [PixW-1:0] value_o,
  output logic            last_o
);

  // front to queue
  logic push;
  cmd_t push_cmd;
  // queue to back
  logic pop, q_full, q_empty;
  cmd_t head_cmd;

  // front: holds row width, open run and column; classifies each pixel
  // into zero, one or two packets and pushes the nonempty ones
  rlp_front #(
    .MaxRun(MaxRun)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .pixel_i    (pixel_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  // decoupling queue so a stalled output does not freeze pixel intake at once
  rlp_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_cmd),
    .pop_i      (pop),
    .pop_data_o (head_cmd),
    .full_o     (q_full),
    .empty_o    (q_empty)
  );

  // back: output register plus a slot for the second packet of a pixel
  rlp_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_empty),
    .q_data_i       (head_cmd),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .packet_header_o(packet_header_o),
    .value_o        (value_o),
    .last_o         (last_o)
  );

endmodule

`default_nettype wire

/* sim/tb_top.sv */
// tb_top: self-checking bench for the grayscale run-length packer
// depends on rlp_pkg and grayscale_run_length_packer; a class predicts the run packets
`timescale 1ns / 100ps

module tb_top;
  import rlp_pkg::*;

  localparam int unsigned MAX_RUN     = MaxRunDef;  // block built with its default
  localparam int          SETTLE_PAD  = 8;          // slack for the pipe to empty out
  localparam int          HOLD_CYCLES = 250;        // long receiver hold-off
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          NUM_PHASES  = 12;
  localparam int          PHASE_ITEMS = 30;

  // one run packet as it leaves the block
  typedef struct packed {
    logic [HdrW-1:0] hdr;
    logic [PixW-1:0] val;
    logic            last;
  } packet_t;

  // predicts the packets for every accepted pixel and holds them in order
  class run_packet_board;
    packet_t         pending_packets[$];
    logic [ColW-1:0] width_reg;
    logic [PixW-1:0] cur_value;
    logic [7:0]      cur_len;
    logic [ColW-1:0] col_pos;
    int              errors;

    function new();
      width_reg = 16'd1;
      cur_value = '0;
      cur_len   = '0;
      col_pos   = '0;
      errors    = 0;
    endfunction

    function void set_row_width(logic [ColW-1:0] w);
      width_reg = w;
    endfunction

    function packet_t make_packet(logic [7:0] len, logic [PixW-1:0] v);
      packet_t    pk;
      logic [7:0] m;
      m       = len - 8'd1;
      pk.hdr  = {HdrFlag, m[6:0]};
      pk.val  = v;
      pk.last = 1'b0;
      return pk;
    endfunction

    function void note_pixel(logic [PixW-1:0] p);
      packet_t         made[$];
      logic [ColW:0]   next_col;
      if (cur_len != 0) begin
        // a different value or a full run closes the open run
        if (p != cur_value || cur_len >= MAX_RUN) begin
          made.push_back(make_packet(cur_len, cur_value));
          cur_value = p;
          cur_len   = 8'd1;
        end else begin
          cur_len = cur_len + 8'd1;
        end
      end else begin
        cur_value = p;
        cur_len   = 8'd1;
      end
      // end of row: also covers a zero width and a width lowered below the column
      next_col = {1'b0, col_pos} + 17'd1;
      if (next_col >= {1'b0, width_reg}) begin
        made.push_back(make_packet(cur_len, cur_value));
        cur_len = '0;
        col_pos = '0;
      end else begin
        col_pos = next_col[ColW-1:0];
      end
      if (made.size() > 0) made[made.size()-1].last = 1'b1;
      foreach (made[i]) pending_packets.push_back(made[i]);
    endfunction

    task report(string what, logic [7:0] got, logic [7:0] want);
      $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
      errors++;
    endtask

    task check_packet(logic [HdrW-1:0] hdr, logic [PixW-1:0] v, logic lst);
      packet_t want;
      if (pending_packets.size() == 0) begin
        report("packet with none expected, header", hdr, 8'h00);
        return;
      end
      want = pending_packets.pop_front();
      if (hdr !== want.hdr) report("header", hdr, want.hdr);
      if (v !== want.val) report("value", v, want.val);
      if (lst !== want.last) report("last", {7'd0, lst}, {7'd0, want.last});
    endtask
  endclass

  // block ports; the inputs are all known from time zero
  logic            clk_i        = 1'b0;
  logic            rst_ni       = 1'b0;
  logic            cfg_we_i     = 1'b0;
  logic [ColW-1:0] cfg_wdata_i  = '0;
  logic            in_valid_i   = 1'b0;
  logic            in_stall_o;
  logic [PixW-1:0] pixel_i      = '0;
  logic            out_valid_o;
  logic            out_stall_i  = 1'b0;
  logic [HdrW-1:0] packet_header_o;
  logic [PixW-1:0] value_o;
  logic            last_o;

  run_packet_board board = new();

  int send_idle_pct = 0;   // chance per cycle that the pixel side holds back
  int recv_idle_pct = 0;   // chance per cycle that the packet side stalls
  bit hold_go       = 1'b0;
  logic hold_on     = 1'b0;
  int cycles        = 0;

  grayscale_run_length_packer u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .pixel_i         (pixel_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .packet_header_o (packet_header_o),
    .value_o         (value_o),
    .last_o          (last_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // watchdog: a stuck handshake or a lost packet ends up here
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // packet side: check each accepted beat, then pick the next stall
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      board.check_packet(packet_header_o, value_o, last_o);
    end
    out_stall_i <= hold_on || ($urandom_range(99) < recv_idle_pct);
  end

  // long hold-off on the packet side so the block fills and stalls its pixel input
  initial begin
    wait (hold_go);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_on <= 1'b0;
  end

  // offer one pixel beat, with random gaps ahead of it, and wait for acceptance
  task send_pixel(input logic [PixW-1:0] p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pixel_i    <= p;
    do @(posedge clk_i); while (in_stall_o);
    board.note_pixel(p);
  endtask

  task send_run(input logic [PixW-1:0] p, input int n);
    repeat (n) send_pixel(p);
  endtask

  // drop valid, wait for every predicted packet, then let the pipe empty out
  task settle();
    in_valid_i <= 1'b0;
    while (board.pending_packets.size() != 0) @(posedge clk_i);
    repeat (SETTLE_PAD) @(posedge clk_i);
  endtask

  task write_row_width(input logic [ColW-1:0] w);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= w;
    @(posedge clk_i);
    board.set_row_width(w);
    cfg_we_i    <= 1'b0;
  endtask

  // random content shaped as runs, with a share of lone noise pixels
  task send_random_phase(input int n);
    int          sent;
    int          len;
    int          kind;
    logic [7:0]  v;
    sent = 0;
    while (sent < n) begin
      kind = $urandom_range(99);
      case ($urandom_range(3))
        0: v = 8'h00;
        1: v = 8'hff;
        default: v = 8'($urandom_range(255));
      endcase
      if (kind < 6) begin
        len = $urandom_range(120, 136);   // can reach the run length cap
      end else if (kind < 80) begin
        len = $urandom_range(1, 6);
      end else begin
        len = 1;
        v   = 8'($urandom_range(255));
      end
      send_run(v, len);
      sent += len;
    end
  endtask

  initial begin
    logic [ColW-1:0] widths [NUM_PHASES];
    widths = '{16'd3, 16'd128, 16'd200, 16'hffff, 16'd1, 16'd7,
               16'd0, 16'd129, 16'd16, 16'd5, 16'd2, 16'd40};

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset width of one
    send_pixel(8'h00);
    send_pixel(8'hff);

    // zero width acts as one
    write_row_width(16'd0);
    send_pixel(8'h00);
    send_pixel(8'hff);
    send_pixel(8'hff);

    // value changes, then a row end that closes two runs at once
    write_row_width(16'd8);
    send_run(8'h07, 3);
    send_run(8'h08, 2);
    send_run(8'h09, 2);
    send_pixel(8'h03);

    // width lowered below the current column mid-row
    write_row_width(16'd10);
    send_run(8'h55, 5);
    write_row_width(16'd3);
    send_pixel(8'h55);

    // width changed mid-row while the column stays inside it
    write_row_width(16'd10);
    send_run(8'h20, 2);
    write_row_width(16'd4);
    send_pixel(8'h20);
    send_pixel(8'h21);

    // random phases: receiver idles more, then sender, then nobody
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph < 4) begin
        send_idle_pct = 33;
        recv_idle_pct = 46;
      end else if (ph < 8) begin
        send_idle_pct = 46;
        recv_idle_pct = 33;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (ph == 11) widths[ph] = ColW'($urandom_range(1, 65535));
      write_row_width(widths[ph]);
      if (ph == 9) hold_go = 1'b1;
      send_random_phase(PHASE_ITEMS);
    end

    settle();
    if (board.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/rlp_pkg.sv
sv/rlp_front.sv
sv/rlp_queue.sv
sv/rlp_back.sv
sv/grayscale_run_length_packer.sv
sim/tb_top.sv
